[hdl/csfi_pkg.sv]
// Shared widths, constants and types for the collision special function interpolator.
package csfi_pkg;

  localparam int unsigned X_W     = 24;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned ROWS    = 3;
  localparam int unsigned SQ_W    = 2 * X_W;
  localparam int unsigned CUBE_W  = 3 * X_W;
  localparam int unsigned QUOT_W  = 34;
  // Starting remainders: 2^61 / x^2 and 2^78 / x^3, with QUOT_W quotient bits left.
  localparam int unsigned SQ_INIT_EXP   = 61 - QUOT_W;
  localparam int unsigned CUBE_INIT_EXP = 78 - QUOT_W;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 96;

  localparam logic signed [VAL_W-1:0] ZERO_SLOPE = 32'sd807725270;
  localparam logic signed [VAL_W-1:0] SAT_MAX    = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] SAT_MIN    = 32'sh80000000;
  localparam logic [35:0]             ONE_Q30    = 36'h040000000;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  typedef logic signed [VAL_W-1:0] sample_t;
  typedef sample_t [ROWS-1:0]      row_set_t;

  // Flags and interpolated values that ride alongside the dividers.
  typedef struct packed {
    logic     zero;
    logic     tail;
    row_set_t interp;
  } side_t;

endpackage

[hdl/collision_special_function_interp.sv]
// Each accepted evaluate word yields one result word; loads give no result.
// Throughput: one word per cycle; the pipeline stalls as a whole only when the output is held.
// The depth is set by the two bit-per-stage dividers for 1/(2x^2) and 1/x^3 (35 stages each).
// Reset clears all valid bits, the output valid included; the sample table is not cleared
// and must be written before it is read.
module collision_special_function_interp #(
  parameter int unsigned SLOTS      = 256,
  parameter int unsigned STEP_SHIFT = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // x[23:0], table_index[33:24], table_value[65:34], zero fill above
  input  logic [csfi_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // action
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // f_value[31:0], f_sum[63:32], f_slope[95:64]
  output logic [csfi_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // used_tail
  output logic                                m_axis_tuser_o
);
  import csfi_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  localparam logic [35:0] LIMIT = 36'(SLOTS - 1) << STEP_SHIFT;
  localparam int unsigned PW = STEP_SHIFT + 34;

  logic en;
  logic accept;
  logic [X_W-1:0]   in_x;
  logic [IDX_W-1:0] in_idx;
  sample_t          in_val;

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i && en;
  assign in_x            = s_axis_tdata_i[23:0];
  assign in_idx          = s_axis_tdata_i[33:24];
  assign in_val          = s_axis_tdata_i[65:34];

  // Slot addresses; out-of-range slots belong to tail words and read slot zero.
  logic [X_W-1:0] slot_full;
  logic [X_W-1:0] slot_next;
  logic [SW-1:0]  rd_lo;
  logic [SW-1:0]  rd_hi;

  assign slot_full = in_x >> STEP_SHIFT;
  assign slot_next = slot_full + X_W'(1);

  always_comb begin
    rd_lo = '0;
    rd_hi = '0;
    if (slot_full < X_W'(SLOTS)) begin
      rd_lo = slot_full[SW-1:0];
      rd_hi = (slot_next < X_W'(SLOTS)) ? slot_next[SW-1:0] : slot_full[SW-1:0];
    end
  end

  row_set_t lo1;
  row_set_t hi1;

  csfi_table #(.SLOTS(SLOTS)) u_table (
    .clk_i      (clk_i),
    .en_i       (en),
    .we_i       (accept && (s_axis_tuser_i == ACT_LOAD)),
    .waddr_i    (in_idx),
    .wdata_i    (in_val),
    .raddr_lo_i (rd_lo),
    .raddr_hi_i (rd_hi),
    .lo_o       (lo1),
    .hi_o       (hi1)
  );

  logic           v1_q, v2_q, v3_q, v4_q;
  logic [X_W-1:0] x1_q, x2_q, x3_q, x4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= accept && (s_axis_tuser_i == ACT_EVAL);
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Stage 2: square of x and the offset-weighted sample differences.
  logic [SQ_W-1:0]        sq2_q;
  row_set_t               lo2_q;
  logic signed [PW-1:0]   prod2_q [ROWS];
  logic signed [STEP_SHIFT:0] off1;

  assign off1 = $signed({1'b0, x1_q[STEP_SHIFT-1:0]});

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q  <= in_x;
      x2_q  <= x1_q;
      sq2_q <= x1_q * x1_q;
      lo2_q <= lo1;
      for (int r = 0; r < ROWS; r++) begin
        prod2_q[r] <= PW'(off1 * ($signed({hi1[r][VAL_W-1], hi1[r]})
                               - $signed({lo1[r][VAL_W-1], lo1[r]})));
      end
    end
  end

  // Stage 3: interpolated rows and partial products of the cube.
  row_set_t          interp3_q;
  logic [SQ_W-1:0]   sq3_q;
  logic [SQ_W-1:0]   pc_lo3_q;
  logic [SQ_W-1:0]   pc_hi3_q;
  logic signed [PW-1:0] step2 [ROWS];

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      step2[r] = prod2_q[r] >>> STEP_SHIFT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x3_q     <= x2_q;
      sq3_q    <= sq2_q;
      pc_lo3_q <= sq2_q[X_W-1:0] * x2_q;
      pc_hi3_q <= sq2_q[SQ_W-1:X_W] * x2_q;
      for (int r = 0; r < ROWS; r++) begin
        interp3_q[r] <= lo2_q[r] + step2[r][VAL_W-1:0];
      end
    end
  end

  // Stage 4: cube, range flags.
  logic [CUBE_W-1:0] cube4_q;
  logic [SQ_W-1:0]   sq4_q;
  side_t             side4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x4_q           <= x3_q;
      sq4_q          <= sq3_q;
      cube4_q        <= CUBE_W'(pc_lo3_q) + (CUBE_W'(pc_hi3_q) << X_W);
      side4_q.zero   <= (x3_q == '0);
      side4_q.tail   <= (36'(x3_q) > LIMIT);
      side4_q.interp <= interp3_q;
    end
  end

  logic              va, vs;
  logic [QUOT_W-1:0] qa, qs;
  logic              ovfa, ovfs;
  side_t             side_out;
  logic [X_W-1:0]    x_out;

  csfi_div #(.DW(SQ_W), .INIT_EXP(SQ_INIT_EXP), .SIDE_W($bits(side_t))) u_div_sq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v4_q),
    .divisor_i (sq4_q),
    .side_i    (side4_q),
    .valid_o   (va),
    .quot_o    (qa),
    .ovf_o     (ovfa),
    .side_o    (side_out)
  );

  csfi_div #(.DW(CUBE_W), .INIT_EXP(CUBE_INIT_EXP), .SIDE_W(X_W)) u_div_cube (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (v4_q),
    .divisor_i (cube4_q),
    .side_i    (x4_q),
    .valid_o   (vs),
    .quot_o    (qs),
    .ovf_o     (ovfs),
    .side_o    (x_out)
  );

  // Saturation of the tail formulas and final selection.
  sample_t     f_val_w, f_sum_w, f_slp_w;
  logic        tail_w;
  logic [35:0] sum_raw;

  assign sum_raw = ONE_Q30 - 36'(qa);

  always_comb begin
    f_val_w = side_out.interp[0];
    f_sum_w = side_out.interp[1];
    f_slp_w = side_out.interp[2];
    tail_w  = 1'b0;
    if (side_out.zero || (x_out == '0)) begin
      f_val_w = '0;
      f_sum_w = '0;
      f_slp_w = ZERO_SLOPE;
    end else if (side_out.tail) begin
      tail_w  = 1'b1;
      f_val_w = (ovfa || (qa > QUOT_W'(SAT_MAX))) ? SAT_MAX : qa[VAL_W-1:0];
      if (ovfa || ($signed(sum_raw) < $signed({{4{1'b1}}, SAT_MIN}))) begin
        f_sum_w = SAT_MIN;
      end else if ($signed(sum_raw) > $signed({4'b0, SAT_MAX})) begin
        f_sum_w = SAT_MAX;
      end else begin
        f_sum_w = sum_raw[VAL_W-1:0];
      end
      f_slp_w = (ovfs || (qs > QUOT_W'(SAT_MAX))) ? SAT_MIN : -qs[VAL_W-1:0];
    end
  end

  logic out_valid_q;
  sample_t f_val_q, f_sum_q, f_slp_q;
  logic    tail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= va && vs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_val_q <= f_val_w;
      f_sum_q <= f_sum_w;
      f_slp_q <= f_slp_w;
      tail_q  <= tail_w;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {f_slp_q, f_sum_q, f_val_q};
  assign m_axis_tuser_o  = tail_q;

endmodule

[hdl/csfi_table.sv]
// Three-row sample memory with one write port and two registered reads per row.
module csfi_table #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic                         we_i,
  input  logic [csfi_pkg::IDX_W-1:0]   waddr_i,
  input  csfi_pkg::sample_t            wdata_i,
  input  logic [$clog2(SLOTS)-1:0]     raddr_lo_i,
  input  logic [$clog2(SLOTS)-1:0]     raddr_hi_i,
  output csfi_pkg::row_set_t           lo_o,
  output csfi_pkg::row_set_t           hi_o
);
  import csfi_pkg::*;

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned AW = 16;
  localparam logic [AW-1:0] ONE_ROW = AW'(SLOTS);
  localparam logic [AW-1:0] TWO_ROW = AW'(2 * SLOTS);
  localparam logic [AW-1:0] ALL_ROW = AW'(3 * SLOTS);

  logic [AW-1:0] addr_w;
  logic [AW-1:0] slot_w;
  logic [ROWS-1:0] row_we;

  assign addr_w = AW'(waddr_i);

  always_comb begin
    row_we = '0;
    slot_w = addr_w;
    if (addr_w < ALL_ROW) begin
      if (addr_w >= TWO_ROW) begin
        row_we[2] = 1'b1;
        slot_w    = addr_w - TWO_ROW;
      end else if (addr_w >= ONE_ROW) begin
        row_we[1] = 1'b1;
        slot_w    = addr_w - ONE_ROW;
      end else begin
        row_we[0] = 1'b1;
      end
    end
  end

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    sample_t mem [SLOTS];

    always_ff @(posedge clk_i) begin
      if (we_i && row_we[r]) begin
        mem[slot_w[SW-1:0]] <= wdata_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_o[r] <= mem[raddr_lo_i];
        hi_o[r] <= mem[raddr_hi_i];
      end
    end
  end

endmodule

[hdl/csfi_div.sv]
// Pipelined restoring divider of a constant power of two by a variable, one bit per stage.
module csfi_div #(
  parameter int unsigned DW       = 48,
  parameter int unsigned INIT_EXP = 27,
  parameter int unsigned SIDE_W   = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [DW-1:0]                 divisor_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic [csfi_pkg::QUOT_W-1:0]   quot_o,
  output logic                          ovf_o,
  output logic [SIDE_W-1:0]             side_o
);
  import csfi_pkg::*;

  localparam logic [DW-1:0] INIT_REM = DW'(1) << INIT_EXP;

  logic [DW-1:0]     rem_q [QUOT_W+1];
  logic [DW-1:0]     dvs_q [QUOT_W+1];
  logic [QUOT_W-1:0] quo_q [QUOT_W+1];
  logic              ovf_q [QUOT_W+1];
  logic              vld_q [QUOT_W+1];
  logic [SIDE_W-1:0] sid_q [QUOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  // When the divisor does not exceed the start remainder the quotient overflows.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= INIT_REM;
      dvs_q[0] <= divisor_i;
      quo_q[0] <= '0;
      ovf_q[0] <= (divisor_i <= INIT_REM);
      sid_q[0] <= side_i;
    end
  end

  for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        take;

    assign trial = {rem_q[s], 1'b0};
    assign diff  = trial - {1'b0, dvs_q[s]};
    assign take  = (trial >= {1'b0, dvs_q[s]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= take ? diff[DW-1:0] : trial[DW-1:0];
        dvs_q[s+1] <= dvs_q[s];
        quo_q[s+1] <= {quo_q[s][QUOT_W-2:0], take};
        ovf_q[s+1] <= ovf_q[s];
        sid_q[s+1] <= sid_q[s];
      end
    end
  end

  assign valid_o = vld_q[QUOT_W];
  assign quot_o  = quo_q[QUOT_W];
  assign ovf_o   = ovf_q[QUOT_W];
  assign side_o  = sid_q[QUOT_W];

endmodule

[verif/tb_collision_special_function_interp.sv]
// Self-checking testbench for the collision special function interpolator.
module tb_collision_special_function_interp;
  timeunit 1ns;
  timeprecision 1ps;

  import csfi_pkg::*;

  localparam int unsigned SLOTS       = 256;
  localparam int unsigned STEP_SHIFT  = 12;
  localparam int unsigned TABLE_WORDS = ROWS * SLOTS;
  localparam int unsigned X_LIMIT     = (SLOTS - 1) << STEP_SHIFT;
  localparam int unsigned X_MAX       = (1 << X_W) - 1;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam longint      CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_PER_PHASE = 280;

  typedef struct {
    sample_t f_value;
    sample_t f_sum;
    sample_t f_slope;
    logic    used_tail;
  } specials_t;

  typedef struct {
    logic                action;
    logic [X_W-1:0]      x;
    logic [IDX_W-1:0]    idx;
    logic [VAL_W-1:0]    val;
    logic                typed;
    specials_t           res;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  s_axis_tuser_i = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;

  logic [VAL_W-1:0] sample_mem [TABLE_WORDS];
  specials_t        pending_results [$];
  int unsigned      send_idle_pct = 19;
  int unsigned      recv_idle_pct = 48;
  int unsigned      hold_seq = 0;
  int unsigned      mismatches = 0;
  longint           cycles = 0;

  collision_special_function_interp #(
    .SLOTS     (SLOTS),
    .STEP_SHIFT(STEP_SHIFT)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic sample_t clamp32(longint v);
    if (v > 64'sd2147483647) return SAT_MAX;
    if (v < -64'sd2147483648) return SAT_MIN;
    return sample_t'(v);
  endfunction

  function automatic longint interp_row(int unsigned row, int unsigned slot,
                                        longint off);
    int unsigned nxt;
    longint lo;
    longint hi;
    nxt = (slot + 1 < SLOTS) ? slot + 1 : slot;
    lo = longint'($signed(sample_mem[row * SLOTS + slot]));
    hi = longint'($signed(sample_mem[row * SLOTS + nxt]));
    // Arithmetic shift of a signed product rounds toward minus infinity.
    return lo + ((off * (hi - lo)) >>> STEP_SHIFT);
  endfunction

  function automatic specials_t eval_specials(logic [X_W-1:0] x);
    specials_t r;
    logic [127:0] xw;
    logic [127:0] inv_sq;
    logic [127:0] inv_cube;
    int unsigned slot;
    longint off;
    r.used_tail = 1'b0;
    if (x == 0) begin
      r.f_value = '0;
      r.f_sum   = '0;
      r.f_slope = ZERO_SLOPE;
    end else if (x > X_LIMIT) begin
      xw = 128'(x);
      inv_sq = (128'd1 << 61) / (xw * xw);
      inv_cube = (128'd1 << 78) / (xw * xw * xw);
      if (inv_cube > (128'd1 << 32)) inv_cube = 128'd1 << 32;
      r.f_value = clamp32(longint'(inv_sq));
      r.f_sum   = clamp32(longint'(ONE_Q30) - longint'(inv_sq));
      r.f_slope = clamp32(-longint'(inv_cube));
      r.used_tail = 1'b1;
    end else begin
      slot = 32'(x >> STEP_SHIFT);
      off = longint'(x & ((1 << STEP_SHIFT) - 1));
      r.f_value = clamp32(interp_row(0, slot, off));
      r.f_sum   = clamp32(interp_row(1, slot, off));
      r.f_slope = clamp32(interp_row(2, slot, off));
    end
    return r;
  endfunction

  // Drives one word from a falling edge and returns on the falling edge after it is taken.
  task automatic send_word(stim_row_t w);
    int unsigned gap;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      gap = $urandom_range(4, 1);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = w.action;
    s_axis_tdata_i  = {6'b0, w.val, w.idx, w.x};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (w.action == ACT_LOAD) begin
      if (w.idx < TABLE_WORDS) sample_mem[w.idx] = w.val;
    end else begin
      pending_results.push_back(w.typed ? w.res : eval_specials(w.x));
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  function automatic stim_row_t random_word();
    stim_row_t w;
    int unsigned pick;
    w.typed = 1'b0;
    w.res = '{default: '0};
    w.x   = X_W'($urandom);
    w.idx = IDX_W'($urandom);
    w.val = $urandom;
    pick = $urandom_range(99);
    w.action = (pick < 25) ? ACT_LOAD : ACT_EVAL;
    if (w.action == ACT_EVAL) begin
      if (pick < 30) w.x = '0;
      else if (pick < 45) w.x = X_W'($urandom_range(X_MAX, X_LIMIT + 1));
      else w.x = X_W'($urandom_range(X_LIMIT, 1));
    end
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin : receiver
    static int unsigned seen_seq = 0;
    static int unsigned hold_left = 0;
    if (hold_seq != seen_seq) begin
      seen_seq = hold_seq;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i = 1'b0;
    end else begin
      m_axis_tready_i = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    specials_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata_o[31:0] !== exp_r.f_value || m_axis_tdata_o[63:32] !== exp_r.f_sum
            || m_axis_tdata_o[95:64] !== exp_r.f_slope || m_axis_tuser_o !== exp_r.used_tail)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: value %0d/%0d sum %0d/%0d slope %0d/%0d tail %0b/%0b",
                     exp_r.f_value, $signed(m_axis_tdata_o[31:0]),
                     exp_r.f_sum, $signed(m_axis_tdata_o[63:32]),
                     exp_r.f_slope, $signed(m_axis_tdata_o[95:64]),
                     exp_r.used_tail, m_axis_tuser_o);
        end
      end
    end
  end

  initial begin
    stim_row_t directed [$];
    stim_row_t w;
    specials_t zero_res;
    specials_t max_res;
    zero_res = '{f_value: '0, f_sum: '0, f_slope: ZERO_SLOPE, used_tail: 1'b0};
    max_res  = '{f_value: 32'sd8192, f_sum: 32'sd1073733632, f_slope: -32'sd64,
                 used_tail: 1'b1};

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Every entry is written before any evaluation reads it.
    for (int unsigned i = 0; i < TABLE_WORDS; i++) begin
      w = random_word();
      w.action = ACT_LOAD;
      w.idx = IDX_W'(i);
      send_word(w);
    end

    // Directed: extreme samples, ignored addresses, both ends of the range and the tail.
    directed = '{
      '{ACT_LOAD, 24'h0,     10'd0,    32'h7fffffff, 1'b0, '{default: '0}},
      '{ACT_LOAD, 24'hffffff, 10'd1,   32'h80000000, 1'b0, '{default: '0}},
      '{ACT_LOAD, 24'h0,     10'd255,  32'h80000000, 1'b0, '{default: '0}},
      '{ACT_LOAD, 24'h0,     10'd767,  32'h7fffffff, 1'b0, '{default: '0}},
      '{ACT_LOAD, 24'h0,     10'd768,  32'h12345678, 1'b0, '{default: '0}},
      '{ACT_LOAD, 24'hffffff, 10'd1023, 32'hffffffff, 1'b0, '{default: '0}},
      '{ACT_EVAL, 24'h0,     10'd0,    32'h0,        1'b1, zero_res},
      '{ACT_EVAL, 24'hffffff, 10'd1023, 32'hffffffff, 1'b1, max_res},
      '{ACT_EVAL, 24'd1,     10'd0,    32'h0,        1'b0, '{default: '0}},
      '{ACT_EVAL, 24'd4095,  10'd0,    32'h0,        1'b0, '{default: '0}},
      '{ACT_EVAL, 24'd4096,  10'd0,    32'h0,        1'b0, '{default: '0}},
      '{ACT_EVAL, 24'd2048,  10'd0,    32'h0,        1'b0, '{default: '0}},
      '{ACT_EVAL, 24'(X_LIMIT), 10'd0, 32'h0,        1'b0, '{default: '0}},
      '{ACT_EVAL, 24'(X_LIMIT - 1), 10'd0, 32'h0,    1'b0, '{default: '0}},
      '{ACT_EVAL, 24'(X_LIMIT + 1), 10'd0, 32'h0,    1'b0, '{default: '0}},
      '{ACT_EVAL, 24'h800000, 10'd0,   32'h0,        1'b0, '{default: '0}}
    };
    foreach (directed[i]) send_word(directed[i]);

    for (int unsigned phase = 0; phase < 3; phase++) begin
      wait_drained();
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 48 : 0;
      recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 19 : 0;
      // In the last phase the output stalls for a long stretch so the pipeline backs up.
      if (phase == 2) hold_seq++;
      for (int unsigned n = 0; n < RANDOM_PER_PHASE; n++) send_word(random_word());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
